[hdl/atrt_pkg.sv]
// Shared types and codes for the animated tile rectangle table.
package atrt_pkg;

  localparam logic [2:0] MODE_SET    = 3'd0;
  localparam logic [2:0] MODE_GRID   = 3'd1;
  localparam logic [2:0] MODE_STAGE  = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_REJ  = 2'd1;
  localparam logic [1:0] ST_PEND = 2'd2;
  localparam logic [1:0] ST_NF   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_x;
    logic       mul_y;
    logic       chk;
    logic       set_rect;
    logic       stage;
    logic       remove;
    logic       clear;
    logic       set_status;
    logic [1:0] status;
    logic       cmt_fail;
    logic       copy_wr;
    logic       cmt_fin;
    logic       i_clr;
    logic       i_inc;
    logic       div_init;
    logic       div_step;
    logic       walk_sub;
    logic       take_frame;
    logic       take_rect;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       lookup;
    logic       timed;
    logic       last;
    logic       in_range;
    logic       tv;
    logic       av;
    logic       stage_ok;
    logic       copy_last;
    logic       div_last;
    logic       walk_hit;
    logic       out_free;
  } sts_t;

endpackage

[hdl/atrt_ctrl.sv]
// Sequencing state machine for the animated tile rectangle table.
module atrt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  atrt_pkg::sts_t sts,
  output atrt_pkg::cmd_t cmd
);
  import atrt_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_MULX   = 5'd2;
  localparam logic [4:0] S_MULY   = 5'd3;
  localparam logic [4:0] S_CHK    = 5'd4;
  localparam logic [4:0] S_SET    = 5'd5;
  localparam logic [4:0] S_STAGE  = 5'd6;
  localparam logic [4:0] S_CMTCHK = 5'd7;
  localparam logic [4:0] S_CPRD   = 5'd8;
  localparam logic [4:0] S_CPWR   = 5'd9;
  localparam logic [4:0] S_CMTFIN = 5'd10;
  localparam logic [4:0] S_LKR    = 5'd11;
  localparam logic [4:0] S_DIVI   = 5'd12;
  localparam logic [4:0] S_DIV    = 5'd13;
  localparam logic [4:0] S_WRD    = 5'd14;
  localparam logic [4:0] S_WCMP   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_DONE;
        case (sts.mode)
          MODE_SET: begin
            if (!sts.lookup) begin
              state_next = S_CHK;
            end else if (!sts.tv) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_NF;
            end else if (sts.timed && sts.av) begin
              state_next = S_DIVI;
            end else begin
              state_next = S_LKR;
            end
          end
          MODE_GRID: state_next = S_MULX;
          MODE_STAGE: state_next = S_CHK;
          MODE_REMOVE: cmd.remove = 1'b1;
          MODE_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status = ST_OK;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status = ST_REJ;
          end
        endcase
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        state_next = (sts.mode == MODE_STAGE) ? S_STAGE : S_SET;
      end
      S_SET: begin
        cmd.set_rect = 1'b1;
        state_next = S_DONE;
      end
      S_STAGE: begin
        cmd.stage = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status = ST_PEND;
        state_next = sts.last ? S_CMTCHK : S_DONE;
      end
      S_CMTCHK: begin
        if (sts.stage_ok && sts.in_range) begin
          cmd.i_clr = 1'b1;
          state_next = S_CPRD;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status = ST_REJ;
          cmd.cmt_fail = 1'b1;
          state_next = S_DONE;
        end
      end
      S_CPRD: state_next = S_CPWR;
      S_CPWR: begin
        cmd.copy_wr = 1'b1;
        if (sts.copy_last) begin
          state_next = S_CMTFIN;
        end else begin
          cmd.i_inc = 1'b1;
          state_next = S_CPRD;
        end
      end
      S_CMTFIN: begin
        cmd.cmt_fin = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status = ST_OK;
        state_next = S_DONE;
      end
      S_LKR: begin
        cmd.take_rect = 1'b1;
        state_next = S_DONE;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.i_clr = 1'b1;
          state_next = S_WRD;
        end
      end
      S_WRD: state_next = S_WCMP;
      S_WCMP: begin
        if (sts.walk_hit) begin
          cmd.take_frame = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.walk_sub = 1'b1;
          cmd.i_inc = 1'b1;
          state_next = S_WRD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/atrt_dp.sv]
// Datapath of the animated tile rectangle table: stores, divider, frame walk, output register.
module atrt_dp #(
  parameter int NUM_TILES     = 256,
  parameter int MAX_FRAMES    = 8,
  parameter int COORD_BITS    = 16,
  parameter int DURATION_BITS = 20,
  parameter int TOTAL_BITS    = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  atrt_pkg::cmd_t cmd,
  output atrt_pkg::sts_t sts,
  input  logic [2:0]    mode,
  input  logic          lookup,
  input  logic [7:0]    tile,
  input  logic [15:0]   pos_x,
  input  logic [15:0]   pos_y,
  input  logic [15:0]   width,
  input  logic [15:0]   height,
  input  logic [19:0]   duration,
  input  logic          last_frame,
  input  logic [31:0]   elapsed,
  input  logic          timed,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [15:0]   rect_x,
  output logic [15:0]   rect_y,
  output logic [15:0]   rect_w,
  output logic [15:0]   rect_h,
  output logic          is_animated,
  output logic [8:0]    tile_count,
  output logic [8:0]    animated_count
);
  import atrt_pkg::*;

  localparam int TW  = $clog2(NUM_TILES);
  localparam int SIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SCW = $clog2(MAX_FRAMES + 1);
  localparam int FAW = $clog2(NUM_TILES * MAX_FRAMES);
  localparam int CNW = $clog2(NUM_TILES + 1);
  localparam int DB  = DURATION_BITS;
  localparam int TB  = TOTAL_BITS;
  localparam int CW  = (TB > DB) ? TB : DB;
  localparam int STW = CW + 1;
  localparam logic [32:0] CMAX = (33'd1 << COORD_BITS) - 33'd1;
  localparam logic [32:0] DMAX = (33'd1 << DURATION_BITS) - 33'd1;
  localparam logic [STW-1:0] TMAX = (STW'(1) << TOTAL_BITS) - STW'(1);

  // latched item
  logic [2:0]  mode_q;
  logic        lookup_q, last_q, timed_q;
  logic [7:0]  tile_q;
  logic [15:0] x_q, y_q, w_q, h_q;
  logic [19:0] dur_q;
  logic [31:0] el_q;

  logic [31:0] px, py;
  logic        ok_q;
  logic [1:0]  st_q;
  logic [63:0] res;

  logic [NUM_TILES-1:0] tvalid, avalid;
  logic [CNW-1:0] dcount, acount;
  logic [SCW-1:0] scount;
  logic [STW-1:0] stot;
  logic           sbad;

  logic [SIW-1:0] i;
  logic [TB-1:0]  rem, tot_q;
  logic [31:0]    dq;
  logic [4:0]     k;
  logic [SCW-1:0] n_q;

  // memories
  logic [63:0]    rect_mem  [NUM_TILES];
  logic [SCW-1:0] cnt_mem   [NUM_TILES];
  logic [TB-1:0]  tot_mem   [NUM_TILES];
  logic [63:0]    frect_mem [NUM_TILES*MAX_FRAMES];
  logic [DB-1:0]  ftime_mem [NUM_TILES*MAX_FRAMES];
  logic [63:0]    srect_mem [MAX_FRAMES];
  logic [DB-1:0]  stime_mem [MAX_FRAMES];

  logic [63:0]    rect_rd, frect_rd, srect_rd;
  logic [SCW-1:0] cnt_rd;
  logic [TB-1:0]  tot_rd;
  logic [DB-1:0]  ftime_rd, stime_rd;

  logic [TW-1:0]  tidx;
  logic [FAW-1:0] fa;
  logic           in_range, tv, av, ok, set_ok, frame_bad;
  logic [31:0]    mul;
  logic [STW-1:0] stot_sum;
  logic [TB:0]    rsh;
  logic           rge;
  logic           hit;

  assign tidx     = TW'(tile_q);
  assign in_range = ({1'b0, tile_q} < 9'(NUM_TILES));
  assign tv       = in_range && tvalid[tidx];
  assign av       = in_range && avalid[tidx];
  assign fa       = FAW'(FAW'(tidx) * FAW'(MAX_FRAMES) + FAW'(i));
  assign mul      = cmd.mul_y ? (y_q * h_q) : (x_q * w_q);
  assign ok       = (w_q != 16'd0) && (h_q != 16'd0)
                    && (({1'b0, px} + 33'(w_q)) <= CMAX)
                    && (({1'b0, py} + 33'(h_q)) <= CMAX);
  assign set_ok   = in_range && ok_q;
  assign frame_bad = !ok_q || (dur_q == 20'd0) || (33'(dur_q) > DMAX)
                     || (scount >= SCW'(MAX_FRAMES));
  assign stot_sum = stot + STW'(dur_q);
  assign rsh      = {rem, dq[31]};
  assign rge      = (rsh >= {1'b0, tot_q});
  assign hit      = (CW'(rem) < CW'(ftime_rd)) || ((SCW'(i) + SCW'(1)) == n_q);

  always_comb begin
    sts.mode      = mode_q;
    sts.lookup    = lookup_q;
    sts.timed     = timed_q;
    sts.last      = last_q;
    sts.in_range  = in_range;
    sts.tv        = tv;
    sts.av        = av;
    sts.stage_ok  = !sbad && (scount != '0);
    sts.copy_last = ((SCW'(i) + SCW'(1)) == scount);
    sts.div_last  = (k == 5'd31);
    sts.walk_hit  = hit;
    sts.out_free  = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid    <= '0;
      avalid    <= '0;
      dcount    <= '0;
      acount    <= '0;
      scount    <= '0;
      stot      <= '0;
      sbad      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        tvalid <= '0;
        avalid <= '0;
        dcount <= '0;
        acount <= '0;
      end else if ((cmd.set_rect && set_ok) || (cmd.remove && tv)) begin
        if (cmd.set_rect && !tv) begin
          tvalid[tidx] <= 1'b1;
          dcount <= dcount + CNW'(1);
        end
        if (cmd.remove) begin
          tvalid[tidx] <= 1'b0;
          dcount <= dcount - CNW'(1);
        end
        if (av) begin
          avalid[tidx] <= 1'b0;
          acount <= acount - CNW'(1);
        end
      end else if (cmd.cmt_fin) begin
        if (!tv) begin
          tvalid[tidx] <= 1'b1;
          dcount <= dcount + CNW'(1);
        end
        if (!av) begin
          avalid[tidx] <= 1'b1;
          acount <= acount + CNW'(1);
        end
      end
      if (cmd.stage) begin
        if (frame_bad) begin
          sbad <= 1'b1;
        end else if (!sbad) begin
          scount <= scount + SCW'(1);
          stot <= stot_sum;
          if (stot_sum > TMAX) begin
            sbad <= 1'b1;
          end
        end
      end
      if (cmd.cmt_fail || cmd.cmt_fin) begin
        scount <= '0;
        stot   <= '0;
        sbad   <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      lookup_q <= lookup;
      tile_q   <= tile;
      x_q      <= pos_x;
      y_q      <= pos_y;
      w_q      <= width;
      h_q      <= height;
      dur_q    <= duration;
      last_q   <= last_frame;
      el_q     <= elapsed;
      timed_q  <= timed;
      px       <= {16'd0, pos_x};
      py       <= {16'd0, pos_y};
      res      <= '0;
    end
    if (cmd.mul_x) px <= mul;
    if (cmd.mul_y) py <= mul;
    if (cmd.chk) ok_q <= ok;
    if (cmd.set_status) st_q <= cmd.status;
    if (cmd.set_rect) st_q <= set_ok ? ST_OK : ST_REJ;
    if (cmd.remove) st_q <= tv ? ST_OK : ST_NF;
    if (cmd.take_rect) begin
      res  <= rect_rd;
      st_q <= ST_OK;
    end
    if (cmd.take_frame) begin
      res  <= frect_rd;
      st_q <= ST_OK;
    end
    if (cmd.i_clr) begin
      i <= '0;
    end else if (cmd.i_inc) begin
      i <= i + SIW'(1);
    end
    if (cmd.div_init) begin
      dq    <= el_q[31] ? 32'd0 : el_q;
      rem   <= '0;
      k     <= '0;
      tot_q <= tot_rd;
      n_q   <= cnt_rd;
    end
    if (cmd.div_step) begin
      rem <= rge ? TB'(rsh - {1'b0, tot_q}) : rsh[TB-1:0];
      dq  <= {dq[30:0], 1'b0};
      k   <= k + 5'd1;
    end
    if (cmd.walk_sub) rem <= TB'(CW'(rem) - CW'(ftime_rd));
    if (cmd.emit) begin
      status         <= st_q;
      rect_x         <= res[63:48];
      rect_y         <= res[47:32];
      rect_w         <= res[31:16];
      rect_h         <= res[15:0];
      is_animated    <= av;
      tile_count     <= 9'(dcount);
      animated_count <= 9'(acount);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_rect && set_ok) begin
      rect_mem[tidx] <= {px[15:0], py[15:0], w_q, h_q};
    end else if (cmd.copy_wr && (i == '0)) begin
      rect_mem[tidx] <= srect_rd;
    end
    rect_rd <= rect_mem[tidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.cmt_fin) begin
      cnt_mem[tidx] <= scount;
      tot_mem[tidx] <= TB'(stot);
    end
    cnt_rd <= cnt_mem[tidx];
    tot_rd <= tot_mem[tidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_wr) begin
      frect_mem[fa] <= srect_rd;
      ftime_mem[fa] <= stime_rd;
    end
    frect_rd <= frect_mem[fa];
    ftime_rd <= ftime_mem[fa];
  end

  always_ff @(posedge clk) begin
    if (cmd.stage && !frame_bad && !sbad) begin
      srect_mem[scount[SIW-1:0]] <= {x_q, y_q, w_q, h_q};
      stime_mem[scount[SIW-1:0]] <= DB'(dur_q);
    end
    srect_rd <= srect_mem[i];
    stime_rd <= stime_mem[i];
  end

  a_anim_sub: assert property (@(posedge clk) disable iff (rst)
    (avalid & ~tvalid) == '0) else $error("animated tile not defined");
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    acount <= dcount) else $error("animated count above tile count");
  a_stage_bound: assert property (@(posedge clk) disable iff (rst)
    scount <= SCW'(MAX_FRAMES)) else $error("staged frames overflow");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid) else $error("result not presented");

endmodule

[hdl/animated_tile_rect_table.sv]
// Top level of the animated tile rectangle table.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   mode lookup tile pos_x pos_y width height
//                                            duration last_frame elapsed timed
//  out      source     out_valid / out_ready status rect_* is_animated tile_count
//                                            animated_count
//
// One item at a time. A committing frame copies each frame out of staging. A timed
// lookup of an animated tile walks the frames after the bit-serial modulo divider
// (32 steps) has reduced the elapsed time modulo the tile's total duration.
// Reset clears all valid bits at once; no clearing pass. The next item is taken
// while a result waits in the output register.
module animated_tile_rect_table #(
  parameter int NUM_TILES     = 256,
  parameter int MAX_FRAMES    = 8,
  parameter int COORD_BITS    = 16,
  parameter int DURATION_BITS = 20,
  parameter int TOTAL_BITS    = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic        lookup,
  input  logic [7:0]  tile,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] width,
  input  logic [15:0] height,
  input  logic [19:0] duration,
  input  logic        last_frame,
  input  logic [31:0] elapsed,
  input  logic        timed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] rect_x,
  output logic [15:0] rect_y,
  output logic [15:0] rect_w,
  output logic [15:0] rect_h,
  output logic        is_animated,
  output logic [8:0]  tile_count,
  output logic [8:0]  animated_count
);
  import atrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  atrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  atrt_dp #(
    .NUM_TILES     (NUM_TILES),
    .MAX_FRAMES    (MAX_FRAMES),
    .COORD_BITS    (COORD_BITS),
    .DURATION_BITS (DURATION_BITS),
    .TOTAL_BITS    (TOTAL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .mode           (mode),
    .lookup         (lookup),
    .tile           (tile),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .width          (width),
    .height         (height),
    .duration       (duration),
    .last_frame     (last_frame),
    .elapsed        (elapsed),
    .timed          (timed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .rect_x         (rect_x),
    .rect_y         (rect_y),
    .rect_w         (rect_w),
    .rect_h         (rect_h),
    .is_animated    (is_animated),
    .tile_count     (tile_count),
    .animated_count (animated_count)
  );

endmodule
